>>> rtl/uepf_pkg.sv
// Package for the USB endpoint address finder: payload structs, register
// indexes, configuration struct and descriptor constants.
// No dependencies.
package uepf_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [7:0] TYPE_INTERFACE = 8'd4;
  localparam logic [7:0] TYPE_ENDPOINT  = 8'd5;
  localparam logic [7:0] MIN_HEADER     = 8'd6;
  localparam logic [1:0] XFER_MASK      = 2'd3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CONFIG_COUNT     = 3'd0,
    REG_WANTED_CONFIG    = 3'd1,
    REG_WANTED_INTERFACE = 3'd2,
    REG_WANTED_ALTERNATE = 3'd3,
    REG_WANTED_DIRECTION = 3'd4,
    REG_DIRECTION_MASK   = 3'd5,
    REG_WANTED_XFER_TYPE = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0] pipe_address;
    logic       malformed;
  } out_item_t;

  typedef struct packed {
    logic [7:0] config_count;
    logic [7:0] wanted_config;
    logic [7:0] wanted_interface;
    logic [7:0] wanted_alternate;
    logic [7:0] wanted_direction;
    logic [7:0] direction_mask;
    logic [1:0] wanted_transfer_type;
  } cfg_t;

endpackage

>>> rtl/usb_endpoint_address_finder.sv
// Top level of the USB endpoint address finder: configuration registers,
// input handshake and result register. Depends on uepf_pkg, uepf_walker.
//
// Usage:
//  - in channel: one descriptor byte per transaction, last_byte marks the end
//    of a configuration descriptor set.
//  - out channel: one transaction per set, issued for the byte with
//    last_byte set: endpoint number (0 if none) and the malformed flag.
//  - cfg channel: register index and 8-bit data, always ready; write only
//    while no set is in progress. Indexes past the last register are ignored.
// Timing: every byte is processed in the cycle it is accepted, one byte per
// clock while in_ready stays high. The result appears in the output register
// in the cycle after the last byte is accepted.
// Stall: in_ready drops only while a result sits in the output register and
// out_ready is low; a result taken in a cycle frees the register for the
// same cycle's input.
// Reset (rst, synchronous): registers return to their defaults, the walk
// state clears and no result is pending.
module usb_endpoint_address_finder (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  uepf_pkg::in_item_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output uepf_pkg::out_item_t                    out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [uepf_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [uepf_pkg::CFG_DATA_W-1:0]        cfg_data
);

  uepf_pkg::cfg_t      cfg;
  uepf_pkg::out_item_t result;
  logic                accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.config_count         <= 8'd1;
      cfg.wanted_config        <= 8'd1;
      cfg.wanted_interface     <= 8'd0;
      cfg.wanted_alternate     <= 8'd0;
      cfg.wanted_direction     <= 8'h80;
      cfg.direction_mask       <= 8'h80;
      cfg.wanted_transfer_type <= 2'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (uepf_pkg::cfg_reg_t'(cfg_index))
        uepf_pkg::REG_CONFIG_COUNT:     cfg.config_count         <= cfg_data;
        uepf_pkg::REG_WANTED_CONFIG:    cfg.wanted_config        <= cfg_data;
        uepf_pkg::REG_WANTED_INTERFACE: cfg.wanted_interface     <= cfg_data;
        uepf_pkg::REG_WANTED_ALTERNATE: cfg.wanted_alternate     <= cfg_data;
        uepf_pkg::REG_WANTED_DIRECTION: cfg.wanted_direction     <= cfg_data;
        uepf_pkg::REG_DIRECTION_MASK:   cfg.direction_mask       <= cfg_data;
        uepf_pkg::REG_WANTED_XFER_TYPE: cfg.wanted_transfer_type <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  uepf_walker u_walker (
    .clk    (clk),
    .rst    (rst),
    .step   (accept),
    .item   (in_data),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && in_data.last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.last_byte) begin
      out_data <= result;
    end
  end

endmodule

>>> rtl/uepf_walker.sv
// Byte walker: block header parsing and descriptor walk, one byte per step.
// Result fields are presented combinationally for the step that ends a set.
// Depends on uepf_pkg.
module uepf_walker (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  uepf_pkg::in_item_t  item,
  input  uepf_pkg::cfg_t      cfg,
  output uepf_pkg::out_item_t result
);

  logic [15:0] block_offset, block_offset_next;
  logic [15:0] block_length, block_length_next;
  logic [7:0]  desc_offset, desc_offset_next;
  logic [7:0]  desc_length, desc_length_next;
  logic [7:0]  desc_type, desc_type_next;
  logic [7:0]  field_byte, field_byte_next;
  logic [7:0]  current_interface, current_interface_next;
  logic [7:0]  current_alternate, current_alternate_next;
  logic [7:0]  blocks_seen, blocks_seen_next;
  logic        block_matched, block_matched_next;
  logic        walk_halted, walk_halted_next;
  logic [3:0]  found_pipe, found_pipe_next;
  logic        error_flag, error_flag_next;
  logic        walking, walking_next;

  logic [7:0]  b;
  logic [7:0]  span;
  logic [7:0]  len_now;
  logic [15:0] blen_now;
  logic        match_now;
  logic        stop;
  logic [16:0] desc_end;
  logic [16:0] o_inc;
  logic        ep_hit;

  assign b    = item.data_byte;
  assign span = (desc_length < uepf_pkg::MIN_HEADER) ? uepf_pkg::MIN_HEADER : desc_length;

  assign ep_hit = (current_interface == cfg.wanted_interface) &&
                  (current_alternate == cfg.wanted_alternate) &&
                  ((b[1:0] & uepf_pkg::XFER_MASK) == cfg.wanted_transfer_type) &&
                  ((field_byte & cfg.direction_mask) == cfg.wanted_direction) &&
                  (field_byte[3:0] != 4'd0);

  always_comb begin
    block_offset_next      = block_offset;
    block_length_next      = block_length;
    desc_offset_next       = desc_offset;
    desc_length_next       = desc_length;
    desc_type_next         = desc_type;
    field_byte_next        = field_byte;
    current_interface_next = current_interface;
    current_alternate_next = current_alternate;
    blocks_seen_next       = blocks_seen;
    block_matched_next     = block_matched;
    walk_halted_next       = walk_halted;
    found_pipe_next        = found_pipe;
    error_flag_next        = error_flag;
    walking_next           = walking;
    len_now                = desc_length;
    blen_now               = block_length;
    match_now              = block_matched;
    stop                   = 1'b0;
    desc_end               = 17'd0;
    o_inc                  = {1'b0, block_offset} + 17'd1;

    if (!walk_halted) begin
      if (walking) begin
        if (desc_offset == 8'd0) begin
          if (b == 8'd0) begin
            // zero-length descriptor ends the walk
            walk_halted_next = 1'b1;
            stop             = 1'b1;
          end else begin
            desc_length_next = b;
            len_now          = b;
          end
        end else if (desc_offset == 8'd1) begin
          desc_type_next = b;
        end else if (desc_offset == 8'd2) begin
          field_byte_next = b;
        end else if (desc_offset == 8'd3 && desc_length >= 8'd4) begin
          if (desc_type == uepf_pkg::TYPE_INTERFACE) begin
            current_interface_next = field_byte;
            current_alternate_next = b;
          end else if (desc_type == uepf_pkg::TYPE_ENDPOINT && ep_hit) begin
            found_pipe_next  = field_byte[3:0];
            walk_halted_next = 1'b1;
            stop             = 1'b1;
          end
        end
        desc_end = {1'b0, block_offset} + {9'd0, len_now};
        if (!stop) begin
          if (({1'b0, desc_offset} + 9'd1) >= {1'b0, len_now}) begin
            if (desc_end >= {1'b0, block_length}) begin
              walk_halted_next = 1'b1;
            end else begin
              block_offset_next = desc_end[15:0];
              desc_offset_next  = 8'd0;
            end
          end else begin
            desc_offset_next = desc_offset + 8'd1;
          end
        end
      end else begin
        if (block_offset == 16'd0) begin
          if (blocks_seen >= cfg.config_count) begin
            walk_halted_next = 1'b1;
            stop             = 1'b1;
          end else begin
            blocks_seen_next   = blocks_seen + 8'd1;
            block_matched_next = 1'b0;
            match_now          = 1'b0;
            desc_length_next   = b;
          end
        end else if (block_offset == 16'd2) begin
          block_length_next = {8'd0, b};
        end else if (block_offset == 16'd3) begin
          blen_now          = {b, block_length[7:0]};
          block_length_next = blen_now;
          if (blen_now < {8'd0, span}) begin
            error_flag_next  = 1'b1;
            walk_halted_next = 1'b1;
            stop             = 1'b1;
          end
        end else if (block_offset == 16'd5) begin
          match_now          = (b == cfg.wanted_config);
          block_matched_next = match_now;
        end
        if (!stop) begin
          if (block_offset >= 16'd5 && match_now && o_inc == {9'd0, span}) begin
            walking_next      = 1'b1;
            block_offset_next = o_inc[15:0];
            desc_offset_next  = 8'd0;
            desc_length_next  = 8'd0;
          end else if (block_offset >= 16'd5 && !match_now &&
                       o_inc >= {1'b0, block_length}) begin
            // skip to the next block header
            block_offset_next = 16'd0;
          end else begin
            block_offset_next = o_inc[15:0];
          end
        end
      end
    end
  end

  assign result.pipe_address = found_pipe_next;
  assign result.malformed    = error_flag_next;

  always_ff @(posedge clk) begin
    if (rst || (step && item.last_byte)) begin
      block_offset      <= '0;
      block_length      <= '0;
      desc_offset       <= '0;
      desc_length       <= '0;
      desc_type         <= '0;
      field_byte        <= '0;
      current_interface <= '0;
      current_alternate <= '0;
      blocks_seen       <= '0;
      block_matched     <= 1'b0;
      walk_halted       <= 1'b0;
      found_pipe        <= '0;
      error_flag        <= 1'b0;
      walking           <= 1'b0;
    end else if (step) begin
      block_offset      <= block_offset_next;
      block_length      <= block_length_next;
      desc_offset       <= desc_offset_next;
      desc_length       <= desc_length_next;
      desc_type         <= desc_type_next;
      field_byte        <= field_byte_next;
      current_interface <= current_interface_next;
      current_alternate <= current_alternate_next;
      blocks_seen       <= blocks_seen_next;
      block_matched     <= block_matched_next;
      walk_halted       <= walk_halted_next;
      found_pipe        <= found_pipe_next;
      error_flag        <= error_flag_next;
      walking           <= walking_next;
    end
  end

endmodule

>>> tb/tb_usb_endpoint_address_finder.sv
// Testbench for usb_endpoint_address_finder: drives descriptor byte streams and
// register writes, predicts each endpoint lookup and checks every result.
// Depends on uepf_pkg and the DUT sources only.
module tb_usb_endpoint_address_finder;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int unsigned {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_CADENCE
  } ready_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  uepf_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  uepf_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [uepf_pkg::CFG_INDEX_W-1:0] cfg_index = uepf_pkg::REG_CONFIG_COUNT;
  logic [uepf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  usb_endpoint_address_finder dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Expected lookup results, oldest first
  uepf_pkg::out_item_t pending_results[$];
  uepf_pkg::out_item_t oldest_result;
  int unsigned fail_count = 0;

  // Register copy and walk state of the lookup predictor
  uepf_pkg::cfg_t cfg_now;
  logic [15:0] blk_pos, blk_total;
  logic [7:0] dsc_pos, dsc_len, dsc_kind, addr_byte;
  logic [7:0] cur_ifc, cur_alt, blocks_taken;
  logic cfg_hit, walk_stopped, in_body, bad_length;
  logic [3:0] pipe_found;

  // Stimulus shaping
  logic [7:0] set_bytes[$];
  logic [7:0] block_body[$];
  bit gaps_on = 1'b1;
  int unsigned burst_left = 0;

  // Receiver side
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  int unsigned cadence_tick = 0;
  ready_mode_t ready_mode = READY_ALWAYS;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  function automatic void clear_walk();
    blk_pos = '0;
    blk_total = '0;
    dsc_pos = '0;
    dsc_len = '0;
    dsc_kind = '0;
    addr_byte = '0;
    cur_ifc = '0;
    cur_alt = '0;
    blocks_taken = '0;
    cfg_hit = 1'b0;
    walk_stopped = 1'b0;
    in_body = 1'b0;
    pipe_found = '0;
    bad_length = 1'b0;
  endfunction

  // Advances the walk by one byte; returns 1 when the byte closes a set.
  function automatic bit predict_byte(input logic [7:0] b, input logic is_last,
                                      output uepf_pkg::out_item_t res);
    int unsigned d, o, span, nxt;
    bit halted_here;
    halted_here = 1'b0;
    res = '0;
    if (!walk_stopped) begin
      if (in_body) begin
        d = 32'(dsc_pos);
        if (d == 0) begin
          if (b == 8'h00) begin
            walk_stopped = 1'b1;
            halted_here = 1'b1;
          end else begin
            dsc_len = b;
          end
        end else if (d == 1) begin
          dsc_kind = b;
        end else if (d == 2) begin
          addr_byte = b;
        end else if (d == 3 && dsc_len >= 8'd4) begin
          if (dsc_kind == uepf_pkg::TYPE_INTERFACE) begin
            cur_ifc = addr_byte;
            cur_alt = b;
          end else if (dsc_kind == uepf_pkg::TYPE_ENDPOINT &&
                       cur_ifc == cfg_now.wanted_interface &&
                       cur_alt == cfg_now.wanted_alternate &&
                       (b[1:0] & uepf_pkg::XFER_MASK) == cfg_now.wanted_transfer_type &&
                       (addr_byte & cfg_now.direction_mask) == cfg_now.wanted_direction &&
                       addr_byte[3:0] != 4'd0) begin
            pipe_found = addr_byte[3:0];
            walk_stopped = 1'b1;
            halted_here = 1'b1;
          end
        end
        if (!halted_here) begin
          if (d + 1 >= 32'(dsc_len)) begin
            nxt = 32'(blk_pos) + 32'(dsc_len);
            if (nxt >= 32'(blk_total)) walk_stopped = 1'b1;
            else begin
              blk_pos = 16'(nxt);
              dsc_pos = '0;
            end
          end else begin
            dsc_pos = 8'(d + 1);
          end
        end
      end else begin
        o = 32'(blk_pos);
        span = 32'((dsc_len < uepf_pkg::MIN_HEADER) ? uepf_pkg::MIN_HEADER : dsc_len);
        if (o == 0) begin
          if (blocks_taken >= cfg_now.config_count) begin
            walk_stopped = 1'b1;
            halted_here = 1'b1;
          end else begin
            blocks_taken = blocks_taken + 8'd1;
            cfg_hit = 1'b0;
            dsc_len = b;
          end
        end else if (o == 2) begin
          blk_total = {8'h00, b};
        end else if (o == 3) begin
          blk_total[15:8] = b;
          if (32'(blk_total) < span) begin
            bad_length = 1'b1;
            walk_stopped = 1'b1;
            halted_here = 1'b1;
          end
        end else if (o == 5) begin
          cfg_hit = (b == cfg_now.wanted_config);
        end
        if (!halted_here) begin
          if (o >= 5 && cfg_hit && o + 1 == span) begin
            in_body = 1'b1;
            blk_pos = 16'(o + 1);
            dsc_pos = '0;
            dsc_len = '0;
          end else if (o >= 5 && !cfg_hit && o + 1 >= 32'(blk_total)) begin
            blk_pos = '0;
          end else begin
            blk_pos = 16'(o + 1);
          end
        end
      end
    end
    if (is_last) begin
      res.pipe_address = pipe_found;
      res.malformed = bad_length;
      clear_walk();
    end
    return is_last;
  endfunction

  // Sends one byte; the sender runs in bursts, with random gaps between them when gaps_on is set.
  task automatic offer_byte(input logic [7:0] value, input logic is_last);
    uepf_pkg::out_item_t res;
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= '{data_byte: value, last_byte: is_last};
    do @(posedge clk); while (!in_ready);
    if (predict_byte(value, is_last, res)) pending_results.push_back(res);
  endtask

  task automatic send_set();
    foreach (set_bytes[i]) offer_byte(set_bytes[i], i == set_bytes.size() - 1);
  endtask

  task automatic wait_results_done();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending_results.size() != 0 && waited < 20000);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      pending_results.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input uepf_pkg::cfg_reg_t r, input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    case (r)
      uepf_pkg::REG_CONFIG_COUNT:     cfg_now.config_count = v;
      uepf_pkg::REG_WANTED_CONFIG:    cfg_now.wanted_config = v;
      uepf_pkg::REG_WANTED_INTERFACE: cfg_now.wanted_interface = v;
      uepf_pkg::REG_WANTED_ALTERNATE: cfg_now.wanted_alternate = v;
      uepf_pkg::REG_WANTED_DIRECTION: cfg_now.wanted_direction = v;
      uepf_pkg::REG_DIRECTION_MASK:   cfg_now.direction_mask = v;
      uepf_pkg::REG_WANTED_XFER_TYPE: cfg_now.wanted_transfer_type = v[1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input uepf_pkg::cfg_t c);
    write_reg(uepf_pkg::REG_CONFIG_COUNT, c.config_count);
    write_reg(uepf_pkg::REG_WANTED_CONFIG, c.wanted_config);
    write_reg(uepf_pkg::REG_WANTED_INTERFACE, c.wanted_interface);
    write_reg(uepf_pkg::REG_WANTED_ALTERNATE, c.wanted_alternate);
    write_reg(uepf_pkg::REG_WANTED_DIRECTION, c.wanted_direction);
    write_reg(uepf_pkg::REG_DIRECTION_MASK, c.direction_mask);
    // upper bits of the transfer type register must be dropped
    write_reg(uepf_pkg::REG_WANTED_XFER_TYPE, {6'($urandom), c.wanted_transfer_type});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int unsigned pick_len(input int unsigned usual);
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : usual;
  endfunction

  function automatic logic [7:0] pick_near(input logic [7:0] want, input int unsigned spread);
    return $urandom_range(0, 1) ? want : 8'($urandom_range(0, spread));
  endfunction

  function automatic void add_descriptor(input int unsigned len, input logic [7:0] kind,
                                         input logic [7:0] b2, input logic [7:0] b3);
    for (int unsigned i = 0; i < len; i++)
      case (i)
        0: block_body.push_back(8'(len));
        1: block_body.push_back(kind);
        2: block_body.push_back(b2);
        3: block_body.push_back(b3);
        default: block_body.push_back(8'($urandom));
      endcase
  endfunction

  // One configuration block whose contents lean toward the current search
  function automatic void add_block();
    int unsigned hdr, hdr_bytes, total, n_if, n_ep;
    logic [7:0] ep_addr, ep_attr;
    block_body.delete();
    n_if = $urandom_range(1, 2);
    for (int unsigned i = 0; i < n_if; i++) begin
      add_descriptor(pick_len(9), uepf_pkg::TYPE_INTERFACE,
                     pick_near(cfg_now.wanted_interface, 2),
                     pick_near(cfg_now.wanted_alternate, 1));
      n_ep = $urandom_range(0, 2);
      for (int unsigned j = 0; j < n_ep; j++) begin
        ep_addr = 8'($urandom);
        if ($urandom_range(0, 1))
          ep_addr = (ep_addr & ~cfg_now.direction_mask) |
                    (cfg_now.wanted_direction & cfg_now.direction_mask);
        ep_attr = 8'($urandom);
        if ($urandom_range(0, 1)) ep_attr[1:0] = cfg_now.wanted_transfer_type;
        add_descriptor(pick_len(7), uepf_pkg::TYPE_ENDPOINT, ep_addr, ep_attr);
      end
      if ($urandom_range(0, 3) == 0)
        add_descriptor($urandom_range(1, 9), 8'($urandom), 8'($urandom), 8'($urandom));
      if ($urandom_range(0, 15) == 0) block_body.push_back(8'h00);
    end
    hdr = pick_len(9);
    hdr_bytes = (hdr < 32'(uepf_pkg::MIN_HEADER)) ? 32'(uepf_pkg::MIN_HEADER) : hdr;
    total = hdr_bytes + block_body.size();
    case ($urandom_range(0, 15))
      0, 1: total = $urandom_range(0, total + 8);
      2: total = $urandom_range(0, 16'hFFFF);
      default: ;
    endcase
    set_bytes.push_back(8'(hdr));
    set_bytes.push_back(8'h02);
    set_bytes.push_back(total[7:0]);
    set_bytes.push_back(total[15:8]);
    set_bytes.push_back(8'($urandom));
    set_bytes.push_back(pick_near(cfg_now.wanted_config, 3));
    for (int unsigned o = 6; o < hdr_bytes; o++) set_bytes.push_back(8'($urandom));
    foreach (block_body[i]) set_bytes.push_back(block_body[i]);
  endfunction

  function automatic void make_random_set();
    int unsigned n;
    set_bytes.delete();
    if ($urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) set_bytes.push_back(8'($urandom));
    end else begin
      n = $urandom_range(1, 2);
      repeat (n) add_block();
      // stream cut short, or trailing bytes after the blocks
      if ($urandom_range(0, 5) == 0)
        set_bytes = set_bytes[0:$urandom_range(0, set_bytes.size() - 1)];
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, 6)) set_bytes.push_back(8'($urandom));
    end
  endfunction

  // Result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: pipe %0d malformed %0b",
                                  out_data.pipe_address, out_data.malformed));
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_data.pipe_address !== oldest_result.pipe_address)
          report_mismatch($sformatf("pipe_address %0h, expected %0h",
                                    out_data.pipe_address, oldest_result.pipe_address));
        if (out_data.malformed !== oldest_result.malformed)
          report_mismatch($sformatf("malformed %0b, expected %0b",
                                    out_data.malformed, oldest_result.malformed));
      end
    end
  end

  // Receiver stall pattern, with long hold-offs on request
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left = 400;
    end
    if (mode_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(32, 400);
    end
    mode_left--;
    cadence_tick++;
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (ready_mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
        READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:      out_ready <= (cadence_tick % 5) != 0;
      endcase
    end
  end

  task automatic test_directed_sets();
    // short header, short descriptor, endpoint number zero, walk end at total
    set_bytes = {8'h00, 8'h02, 8'h0D, 8'h00, 8'hFF, 8'h01,
                 8'h03, 8'h05, 8'h81,
                 8'h04, 8'h05, 8'h80, 8'h03};
    send_set();
    // first descriptor past the block end still examined, match found
    set_bytes = {8'h06, 8'h02, 8'h06, 8'h00, 8'h00, 8'h01,
                 8'h04, 8'h05, 8'h8F, 8'hFF};
    send_set();
    // total length below the header length
    set_bytes = {8'hFF, 8'h02, 8'h08, 8'h00};
    send_set();
    wait_results_done();
  endtask

  task automatic test_result_backpressure();
    gaps_on = 1'b0;
    hold_requests++;
    repeat (40) begin
      set_bytes.delete();
      repeat ($urandom_range(1, 3)) set_bytes.push_back(8'($urandom));
      send_set();
    end
    wait_results_done();
  endtask

  task automatic test_random_walks();
    uepf_pkg::cfg_t c;
    int unsigned bytes_out, sets_out, phase;
    bytes_out = 0;
    sets_out = 0;
    phase = 0;
    while (bytes_out < 1800 || sets_out < 24) begin
      case (phase)
        1: c = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 2'd3};
        2: c = '{8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0};
        default: begin
          c.config_count = ($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom_range(1, 3));
          c.wanted_config = 8'($urandom_range(0, 3));
          c.wanted_interface = 8'($urandom_range(0, 2));
          c.wanted_alternate = 8'($urandom_range(0, 1));
          c.direction_mask = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'h80;
          c.wanted_direction = 8'($urandom) & c.direction_mask;
          if ($urandom_range(0, 7) == 0) c.wanted_direction = 8'($urandom);
          c.wanted_transfer_type = 2'($urandom_range(0, 3));
        end
      endcase
      set_config(c);
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (3) begin
        make_random_set();
        bytes_out += set_bytes.size();
        send_set();
        sets_out++;
      end
      wait_results_done();
      phase++;
    end
  endtask

  initial begin
    cfg_now = '{8'd1, 8'd1, 8'd0, 8'd0, 8'h80, 8'h80, 2'd3};
    clear_walk();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_sets();
    test_result_backpressure();
    test_random_walks();
    wait_results_done();
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #400_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
